// ===== src/outbound_frame_queue_evict_assert.svh =====
// Assertion macros for the outbound frame queue modules; used by ofqe_ctrl.
// No dependencies; included inside module bodies.
`ifndef OUTBOUND_FRAME_QUEUE_EVICT_ASSERT_SVH
`define OUTBOUND_FRAME_QUEUE_EVICT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define OFQE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define OFQE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ofqe_pkg.sv =====
// Shared types and constants for the outbound frame queue.
// No dependencies; imported by the controller, datapath and top level.
package ofqe_pkg;

    localparam int FUNC_W     = 2;
    localparam int TYPE_W     = 8;
    localparam int SEQ_W      = 8;
    localparam int LEN_W      = 10;
    localparam int HANDLE_W   = 16;
    localparam int MODE_W     = 2;
    localparam int HELD_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ENQUEUE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TAKE    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

    // Eviction modes (any other code means no eviction)
    localparam logic [MODE_W-1:0] EVICT_LOG        = 2'd1;
    localparam logic [MODE_W-1:0] EVICT_LOG_REPORT = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_TYPE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_TYPE = 1'd1;

    // Sequence numbering
    localparam logic [SEQ_W-1:0] SEQ_AUTO  = 8'd0;
    localparam logic [SEQ_W-1:0] SEQ_FIRST = 8'd1;

    localparam logic [CFG_DATA_W-1:0] LOG_CODE_RESET    = 8'd0;
    localparam logic [CFG_DATA_W-1:0] REPORT_CODE_RESET = 8'd1;

    // One stored frame descriptor
    typedef struct packed {
        logic [TYPE_W-1:0]   ftype;
        logic [SEQ_W-1:0]    seq;
        logic [LEN_W-1:0]    length;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load;     // latch item, clear results and scan state
        logic rd;       // read entry at offset (plus one if rd_next)
        logic rd_next;
        logic chk;      // compare read entry against class codes
        logic off_inc;
        logic drop;     // commit victim: drop result, offset to victim
        logic shrink;   // count minus one after compaction
        logic wr_move;  // write read data back one place down
        logic wr_new;   // store new item at tail
        logic take;     // pop head into result
        logic clear;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [MODE_W-1:0] mode;
        logic len_ok;
        logic full;
        logic empty;
        logic last_entry;   // offset + 1 reaches count
        logic log_hit;      // read entry is a log entry
        logic victim_found;
    } status_t;

endpackage

// ===== src/outbound_frame_queue_evict.sv =====
// Channel   | handshake                 | payload
// ----------+---------------------------+---------------------------------------------
// item in   | start, taken when !busy   | func, frame_type, seq_in, payload_length,
//           |                           | payload_handle, evict_mode
// result    | done, one-cycle strobe    | accepted, head_*, dropped, dropped_handle,
//           |                           | entries_held, irq_level
// config    | cfg_write, no wait        | cfg_index, cfg_data
//
// Enqueue with room and take of a held entry: dispatch, then a write or take state,
// then the result. Clear, take on empty, unused selector, oversized length or full
// with no eviction mode: dispatch, then the result. Enqueue on a full queue: a
// read/compare scan from the oldest entry (up to the oldest log entry, or all
// entries when no log entry is held), then, if a victim is found, a read/write move
// of each younger entry one place down and the write of the new item.
// Reset (rst_n, async low) empties the queue; no memory clearing pass.
// The receiver cannot stall: each result is shown for the one cycle of done.
// Top level of the outbound frame queue. Depends on ofqe_pkg, ofqe_ctrl and
// ofqe_datapath.
module outbound_frame_queue_evict #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_PAYLOAD = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    output logic                            done,
    input  logic                            cfg_write,
    input  logic [ofqe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ofqe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [ofqe_pkg::FUNC_W-1:0]     func,
    input  logic [ofqe_pkg::TYPE_W-1:0]     frame_type,
    input  logic [ofqe_pkg::SEQ_W-1:0]      seq_in,
    input  logic [ofqe_pkg::LEN_W-1:0]      payload_length,
    input  logic [ofqe_pkg::HANDLE_W-1:0]   payload_handle,
    input  logic [ofqe_pkg::MODE_W-1:0]     evict_mode,
    output logic                            accepted,
    output logic                            head_valid,
    output logic [ofqe_pkg::TYPE_W-1:0]     head_type,
    output logic [ofqe_pkg::SEQ_W-1:0]      head_seq,
    output logic [ofqe_pkg::LEN_W-1:0]      head_length,
    output logic [ofqe_pkg::HANDLE_W-1:0]   head_handle,
    output logic                            dropped,
    output logic [ofqe_pkg::HANDLE_W-1:0]   dropped_handle,
    output logic [ofqe_pkg::HELD_W-1:0]     entries_held,
    output logic                            irq_level
);
    import ofqe_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    ofqe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .status (status),
        .cmd    (cmd)
    );

    // Storage and arithmetic
    ofqe_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .func           (func),
        .frame_type     (frame_type),
        .seq_in         (seq_in),
        .payload_length (payload_length),
        .payload_handle (payload_handle),
        .evict_mode     (evict_mode),
        .accepted       (accepted),
        .head_valid     (head_valid),
        .head_type      (head_type),
        .head_seq       (head_seq),
        .head_length    (head_length),
        .head_handle    (head_handle),
        .dropped        (dropped),
        .dropped_handle (dropped_handle),
        .entries_held   (entries_held),
        .irq_level      (irq_level)
    );

endmodule

// ===== src/ofqe_ctrl.sv =====
// Sequencing controller of the outbound frame queue.
// Depends on ofqe_pkg and outbound_frame_queue_evict_assert.svh.
module ofqe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    input  ofqe_pkg::status_t status,
    output ofqe_pkg::cmd_t    cmd
);
    import ofqe_pkg::*;

    `include "outbound_frame_queue_evict_assert.svh"

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EVICT,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_WRITE,
        ST_TAKE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (status.func)
                    FUNC_ENQUEUE:
                    begin
                        priority if (!status.len_ok)
                            state_next = ST_DONE;
                        else if (!status.full)
                            state_next = ST_WRITE;
                        else if (status.mode == EVICT_LOG || status.mode == EVICT_LOG_REPORT)
                            state_next = ST_SCAN_RD;
                        else
                            state_next = ST_DONE;
                    end
                    FUNC_TAKE:
                    begin
                        if (status.empty)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.rd     = 1'b1;
                            state_next = ST_TAKE;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            // scan from oldest, one entry per read/compare pair
            ST_SCAN_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                cmd.chk = 1'b1;
                if (status.log_hit || status.last_entry)
                begin
                    state_next = ST_EVICT;
                end
                else
                begin
                    cmd.off_inc = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_EVICT:
            begin
                if (status.victim_found)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_MOVE_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            // close the gap: move each younger entry one place down
            ST_MOVE_RD:
            begin
                if (status.last_entry)
                begin
                    cmd.shrink = 1'b1;
                    state_next = ST_WRITE;
                end
                else
                begin
                    cmd.rd      = 1'b1;
                    cmd.rd_next = 1'b1;
                    state_next  = ST_MOVE_WR;
                end
            end
            ST_MOVE_WR:
            begin
                cmd.wr_move = 1'b1;
                cmd.off_inc = 1'b1;
                state_next  = ST_MOVE_RD;
            end
            ST_WRITE:
            begin
                cmd.wr_new = 1'b1;
                state_next = ST_DONE;
            end
            ST_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `OFQE_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item left block idle")
    `OFQE_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy, "block stayed busy after result")
    `OFQE_ASSERT_IMPL(a_write_room, clk, rst_n, cmd.wr_new, !status.full, "insert into full queue")
    `OFQE_ASSERT_IMPL(a_take_held, clk, rst_n, cmd.take, !status.empty, "take from empty queue")
    `OFQE_ASSERT_IMPL(a_drop_victim, clk, rst_n, cmd.drop, status.victim_found && status.full,
        "eviction without victim or room")

endmodule

// ===== src/ofqe_datapath.sv =====
// Datapath of the outbound frame queue: descriptor memory, pointers,
// class scan registers, sequence counter, config and result registers.
// Depends on ofqe_pkg.
module ofqe_datapath #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_PAYLOAD = 512
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ofqe_pkg::cmd_t                    cmd,
    output ofqe_pkg::status_t                 status,
    input  logic                              cfg_write,
    input  logic [ofqe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ofqe_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [ofqe_pkg::FUNC_W-1:0]       func,
    input  logic [ofqe_pkg::TYPE_W-1:0]       frame_type,
    input  logic [ofqe_pkg::SEQ_W-1:0]        seq_in,
    input  logic [ofqe_pkg::LEN_W-1:0]        payload_length,
    input  logic [ofqe_pkg::HANDLE_W-1:0]     payload_handle,
    input  logic [ofqe_pkg::MODE_W-1:0]       evict_mode,
    output logic                              accepted,
    output logic                              head_valid,
    output logic [ofqe_pkg::TYPE_W-1:0]       head_type,
    output logic [ofqe_pkg::SEQ_W-1:0]        head_seq,
    output logic [ofqe_pkg::LEN_W-1:0]        head_length,
    output logic [ofqe_pkg::HANDLE_W-1:0]     head_handle,
    output logic                              dropped,
    output logic [ofqe_pkg::HANDLE_W-1:0]     dropped_handle,
    output logic [ofqe_pkg::HELD_W-1:0]       entries_held,
    output logic                              irq_level
);
    import ofqe_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // head + offset, wrapped into the ring (sum stays below twice the depth)
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [CNT_W-1:0] ofs);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
        if (sum >= (CNT_W+1)'(QUEUE_DEPTH))
            sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
        return sum[PTR_W-1:0];
    endfunction

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    // latched item
    logic [FUNC_W-1:0]   func_reg;
    logic [TYPE_W-1:0]   type_in_reg;
    logic [SEQ_W-1:0]    seq_in_reg;
    logic [LEN_W-1:0]    len_in_reg;
    logic [HANDLE_W-1:0] handle_in_reg;
    logic [MODE_W-1:0]   mode_reg;

    logic [CFG_DATA_W-1:0] log_code_reg;
    logic [CFG_DATA_W-1:0] report_code_reg;

    logic [PTR_W-1:0] head_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] off_reg;
    logic [SEQ_W-1:0] next_seq_reg;
    logic [SEQ_W-1:0] next_seq_next;

    // oldest match of each class seen by the scan
    logic                log_found_reg;
    logic [PTR_W-1:0]    log_off_reg;
    logic [HANDLE_W-1:0] log_handle_reg;
    logic                rep_found_reg;
    logic [PTR_W-1:0]    rep_off_reg;
    logic [HANDLE_W-1:0] rep_handle_reg;

    logic                accepted_reg;
    logic                head_valid_reg;
    entry_t              head_entry_reg;
    logic                dropped_reg;
    logic [HANDLE_W-1:0] dropped_handle_reg;

    logic [CNT_W-1:0]    rd_ofs;
    logic [PTR_W-1:0]    rd_addr;
    logic [PTR_W-1:0]    wr_addr;
    entry_t              wr_data;
    entry_t              new_entry;
    logic                report_hit;
    logic [PTR_W-1:0]    victim_off;
    logic [HANDLE_W-1:0] victim_handle;

    // Addresses and write data
    always_comb
    begin
        rd_ofs  = CNT_W'(off_reg) + CNT_W'(cmd.rd_next);
        rd_addr = wrap_add(head_reg, rd_ofs);
        if (cmd.wr_new)
            wr_addr = wrap_add(head_reg, count_reg);
        else
            wr_addr = wrap_add(head_reg, CNT_W'(off_reg));

        new_entry.ftype  = type_in_reg;
        new_entry.seq    = (seq_in_reg == SEQ_AUTO) ? next_seq_reg : seq_in_reg;
        new_entry.length = len_in_reg;
        new_entry.handle = handle_in_reg;
        wr_data = cmd.wr_new ? new_entry : rd_data_reg;
    end

    // Sequence counter skips zero on wrap
    always_comb
    begin
        next_seq_next = next_seq_reg + SEQ_W'(1);
        if (next_seq_next == SEQ_AUTO)
            next_seq_next = SEQ_FIRST;
    end

    // Scan compare and victim choice
    assign report_hit    = (rd_data_reg.ftype == report_code_reg);
    assign victim_off    = log_found_reg ? log_off_reg : rep_off_reg;
    assign victim_handle = log_found_reg ? log_handle_reg : rep_handle_reg;

    // Status to controller
    always_comb
    begin
        status.func         = func_reg;
        status.mode         = mode_reg;
        status.len_ok       = (len_in_reg <= LEN_W'(MAX_PAYLOAD));
        status.full         = (count_reg == CNT_W'(QUEUE_DEPTH));
        status.empty        = (count_reg == '0);
        status.last_entry   = ((CNT_W'(off_reg) + CNT_W'(1)) >= count_reg);
        status.log_hit      = (rd_data_reg.ftype == log_code_reg);
        status.victim_found = log_found_reg
                            || (mode_reg == EVICT_LOG_REPORT && rep_found_reg);
    end

    // Descriptor memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
            rd_data_reg <= mem[rd_addr];
        if (cmd.wr_new || cmd.wr_move)
            mem[wr_addr] <= wr_data;
    end

    // Item latch and scan payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg      <= func;
            type_in_reg   <= frame_type;
            seq_in_reg    <= seq_in;
            len_in_reg    <= payload_length;
            handle_in_reg <= payload_handle;
            mode_reg      <= evict_mode;
        end
        if (cmd.chk && !log_found_reg && status.log_hit)
        begin
            log_off_reg    <= off_reg;
            log_handle_reg <= rd_data_reg.handle;
        end
        if (cmd.chk && !rep_found_reg && report_hit)
        begin
            rep_off_reg    <= off_reg;
            rep_handle_reg <= rd_data_reg.handle;
        end
        if (cmd.take)
            head_entry_reg <= rd_data_reg;
        if (cmd.drop)
            dropped_handle_reg <= victim_handle;
    end

    // Control state: config, pointers, counter, flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_code_reg    <= LOG_CODE_RESET;
            report_code_reg <= REPORT_CODE_RESET;
            head_reg        <= '0;
            count_reg       <= '0;
            off_reg         <= '0;
            next_seq_reg    <= SEQ_FIRST;
            log_found_reg   <= 1'b0;
            rep_found_reg   <= 1'b0;
            accepted_reg    <= 1'b0;
            head_valid_reg  <= 1'b0;
            dropped_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_LOG_TYPE:    log_code_reg    <= cfg_data;
                    CFG_REPORT_TYPE: report_code_reg <= cfg_data;
                    default:         log_code_reg    <= log_code_reg;
                endcase
            end

            if (cmd.load)
            begin
                accepted_reg   <= 1'b0;
                head_valid_reg <= 1'b0;
                dropped_reg    <= 1'b0;
                log_found_reg  <= 1'b0;
                rep_found_reg  <= 1'b0;
            end
            if (cmd.chk && status.log_hit)
                log_found_reg <= 1'b1;
            if (cmd.chk && report_hit)
                rep_found_reg <= 1'b1;

            // scan / compaction offset
            priority if (cmd.load)
                off_reg <= '0;
            else if (cmd.drop)
                off_reg <= victim_off;
            else if (cmd.off_inc)
                off_reg <= off_reg + PTR_W'(1);

            // entry count
            priority if (cmd.clear)
                count_reg <= '0;
            else if (cmd.wr_new)
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.shrink || cmd.take)
                count_reg <= count_reg - CNT_W'(1);

            if (cmd.take)
            begin
                head_reg       <= wrap_add(head_reg, CNT_W'(1));
                head_valid_reg <= 1'b1;
            end
            if (cmd.drop)
                dropped_reg <= 1'b1;
            if (cmd.wr_new)
            begin
                accepted_reg <= 1'b1;
                if (seq_in_reg == SEQ_AUTO)
                    next_seq_reg <= next_seq_next;
            end
        end
    end

    // Result fields, zero where not meaningful
    assign accepted       = accepted_reg;
    assign head_valid     = head_valid_reg;
    assign head_type      = head_valid_reg ? head_entry_reg.ftype  : '0;
    assign head_seq       = head_valid_reg ? head_entry_reg.seq    : '0;
    assign head_length    = head_valid_reg ? head_entry_reg.length : '0;
    assign head_handle    = head_valid_reg ? head_entry_reg.handle : '0;
    assign dropped        = dropped_reg;
    assign dropped_handle = dropped_reg ? dropped_handle_reg : '0;
    assign entries_held   = HELD_W'(count_reg);
    assign irq_level      = (count_reg != '0);

endmodule

// ===== test/outbound_frame_queue_evict_tb.sv =====
// Self-checking testbench for outbound_frame_queue_evict: directed and random frame traffic
// against a behavioral queue predictor. Depends on ofqe_pkg and the
// outbound_frame_queue_evict RTL only.
module outbound_frame_queue_evict_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ofqe_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_PAYLOAD = 512;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4 * QUEUE_DEPTH + 16;

    // Codes the package leaves unnamed
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] EVICT_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] EVICT_SPARE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [TYPE_W-1:0]   ftype;
        logic [SEQ_W-1:0]    seq;
        logic [LEN_W-1:0]    length;
        logic [HANDLE_W-1:0] handle;
        logic [MODE_W-1:0]   mode;
    } frame_req_t;

    typedef struct packed {
        logic                accepted;
        logic                head_valid;
        logic [TYPE_W-1:0]   head_type;
        logic [SEQ_W-1:0]    head_seq;
        logic [LEN_W-1:0]    head_length;
        logic [HANDLE_W-1:0] head_handle;
        logic                dropped;
        logic [HANDLE_W-1:0] dropped_handle;
        logic [HELD_W-1:0]   entries_held;
        logic                irq_level;
    } frame_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  done;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LOG_TYPE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic [FUNC_W-1:0]     func = FUNC_TAKE;
    logic [TYPE_W-1:0]     frame_type = '0;
    logic [SEQ_W-1:0]      seq_in = '0;
    logic [LEN_W-1:0]      payload_length = '0;
    logic [HANDLE_W-1:0]   payload_handle = '0;
    logic [MODE_W-1:0]     evict_mode = EVICT_NONE;
    logic                  accepted;
    logic                  head_valid;
    logic [TYPE_W-1:0]     head_type;
    logic [SEQ_W-1:0]      head_seq;
    logic [LEN_W-1:0]      head_length;
    logic [HANDLE_W-1:0]   head_handle;
    logic                  dropped;
    logic [HANDLE_W-1:0]   dropped_handle;
    logic [HELD_W-1:0]     entries_held;
    logic                  irq_level;

    // Predictor state: held descriptors, sequence counter, class codes
    entry_t                held_frames[$];
    logic [SEQ_W-1:0]      next_seq = SEQ_FIRST;
    logic [CFG_DATA_W-1:0] log_code = LOG_CODE_RESET;
    logic [CFG_DATA_W-1:0] report_code = REPORT_CODE_RESET;
    bit                    seq_wrapped = 1'b0;

    frame_result_t         pending_results[$];
    frame_result_t         oldest_result;
    int                    mismatches = 0;
    int                    cycle_count = 0;
    int                    burst_left = 0;

    outbound_frame_queue_evict #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .done          (done),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .frame_type    (frame_type),
        .seq_in        (seq_in),
        .payload_length(payload_length),
        .payload_handle(payload_handle),
        .evict_mode    (evict_mode),
        .accepted      (accepted),
        .head_valid    (head_valid),
        .head_type     (head_type),
        .head_seq      (head_seq),
        .head_length   (head_length),
        .head_handle   (head_handle),
        .dropped       (dropped),
        .dropped_handle(dropped_handle),
        .entries_held  (entries_held),
        .irq_level     (irq_level)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Removes the oldest held frame of the given type, if any
    function automatic bit evict_oldest(input logic [TYPE_W-1:0] code,
                                        output logic [HANDLE_W-1:0] victim);
        victim = '0;
        foreach (held_frames[i])
        begin
            if (held_frames[i].ftype == code)
            begin
                victim = held_frames[i].handle;
                held_frames.delete(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Applies one item to the predictor state and returns its result
    function automatic frame_result_t predict_frame(input frame_req_t r);
        frame_result_t       res;
        entry_t              e;
        logic [HANDLE_W-1:0] victim;
        bit                  evicted;
        res = '0;
        evicted = 1'b0;
        case (r.func)
            FUNC_ENQUEUE:
            begin
                if (r.length <= MAX_PAYLOAD)
                begin
                    if (held_frames.size() >= QUEUE_DEPTH)
                    begin
                        if (r.mode == EVICT_LOG || r.mode == EVICT_LOG_REPORT)
                            evicted = evict_oldest(log_code, victim);
                        if (!evicted && r.mode == EVICT_LOG_REPORT)
                            evicted = evict_oldest(report_code, victim);
                        if (evicted)
                        begin
                            res.dropped = 1'b1;
                            res.dropped_handle = victim;
                        end
                    end
                    if (held_frames.size() < QUEUE_DEPTH)
                    begin
                        e.ftype = r.ftype;
                        e.length = r.length;
                        e.handle = r.handle;
                        if (r.seq != SEQ_AUTO)
                            e.seq = r.seq;
                        else
                        begin
                            // counter skips zero on wrap
                            e.seq = next_seq;
                            next_seq = next_seq + 1'b1;
                            if (next_seq == SEQ_AUTO)
                            begin
                                next_seq = SEQ_FIRST;
                                seq_wrapped = 1'b1;
                            end
                        end
                        held_frames.push_back(e);
                        res.accepted = 1'b1;
                    end
                end
            end
            FUNC_TAKE:
            begin
                if (held_frames.size() > 0)
                begin
                    e = held_frames.pop_front();
                    res.head_valid = 1'b1;
                    res.head_type = e.ftype;
                    res.head_seq = e.seq;
                    res.head_length = e.length;
                    res.head_handle = e.handle;
                end
            end
            FUNC_CLEAR:
                held_frames.delete();
            default:
                ;
        endcase
        res.entries_held = HELD_W'(held_frames.size());
        res.irq_level = (held_frames.size() > 0);
        return res;
    endfunction

    function automatic frame_req_t make_enqueue(input logic [TYPE_W-1:0] ftype,
                                                input logic [SEQ_W-1:0] seq,
                                                input logic [LEN_W-1:0] length,
                                                input logic [HANDLE_W-1:0] handle,
                                                input logic [MODE_W-1:0] mode);
        frame_req_t r;
        r.func = FUNC_ENQUEUE;
        r.ftype = ftype;
        r.seq = seq;
        r.length = length;
        r.handle = handle;
        r.mode = mode;
        return r;
    endfunction

    // Non-enqueue item; the unused fields carry noise
    function automatic frame_req_t make_op(input logic [FUNC_W-1:0] op);
        frame_req_t r;
        r.func = op;
        r.ftype = TYPE_W'($urandom);
        r.seq = SEQ_W'($urandom);
        r.length = LEN_W'($urandom);
        r.handle = HANDLE_W'($urandom);
        r.mode = MODE_W'($urandom);
        return r;
    endfunction

    // Types lean on the droppable classes so evictions find victims
    function automatic logic [TYPE_W-1:0] pick_type();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return log_code;
        else if (sel < 6)
            return report_code;
        return TYPE_W'($urandom_range(0, 255));
    endfunction

    function automatic frame_req_t random_frame(input int enq_pct);
        frame_req_t r;
        int         pick;
        int         sel;
        pick = $urandom_range(0, 99);
        if (pick < enq_pct)
            r.func = FUNC_ENQUEUE;
        else if (pick < 96)
            r.func = FUNC_TAKE;
        else if (pick < 98)
            r.func = FUNC_CLEAR;
        else
            r.func = FUNC_UNUSED;
        r.ftype = pick_type();
        r.seq = ($urandom_range(0, 2) == 0) ? SEQ_AUTO : SEQ_W'($urandom_range(0, 255));
        sel = $urandom_range(0, 19);
        case (sel)
            0: r.length = LEN_W'(MAX_PAYLOAD);
            1: r.length = LEN_W'($urandom_range(MAX_PAYLOAD + 1, 1023));
            2: r.length = '1;
            default: r.length = LEN_W'($urandom_range(0, MAX_PAYLOAD));
        endcase
        r.handle = HANDLE_W'($urandom);
        sel = $urandom_range(0, 9);
        if (sel == 0)
            r.mode = EVICT_NONE;
        else if (sel == 1)
            r.mode = EVICT_SPARE;
        else if (sel < 6)
            r.mode = EVICT_LOG;
        else
            r.mode = EVICT_LOG_REPORT;
        return r;
    endfunction

    // Sends one item after a random gap; start stays high when the gap is zero
    task automatic issue_frame(input frame_req_t r);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 29) == 0)
        begin
            burst_left = $urandom_range(10, 30);
            gap = 0;
        end
        else
            gap = $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        func <= r.func;
        frame_type <= r.ftype;
        seq_in <= r.seq;
        payload_length <= r.length;
        payload_handle <= r.handle;
        evict_mode <= r.mode;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_frame(r));
    endtask

    // Lowers start and waits until every expected result has come back
    task automatic wait_for_idle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0 || busy);
    endtask

    task automatic set_codes(input logic [CFG_DATA_W-1:0] log_val,
                             input logic [CFG_DATA_W-1:0] report_val);
        cfg_write <= 1'b1;
        cfg_index <= CFG_LOG_TYPE;
        cfg_data <= log_val;
        @(posedge clk);
        cfg_index <= CFG_REPORT_TYPE;
        cfg_data <= report_val;
        @(posedge clk);
        cfg_write <= 1'b0;
        log_code = log_val;
        report_code = report_val;
        @(posedge clk);
    endtask

    // Take, clear and unused selector on an empty queue, oversized enqueue
    task automatic test_empty_queue();
        issue_frame(make_op(FUNC_TAKE));
        issue_frame(make_op(FUNC_UNUSED));
        issue_frame(make_op(FUNC_CLEAR));
        issue_frame(make_enqueue(8'h40, SEQ_AUTO, '1, 16'h0BAD, EVICT_LOG_REPORT));
    endtask

    // Fills the queue with both droppable classes and field extremes
    task automatic test_fill_queue();
        logic [TYPE_W-1:0]   ftype;
        logic [SEQ_W-1:0]    seq;
        logic [LEN_W-1:0]    length;
        logic [HANDLE_W-1:0] handle;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (i == 3 || i == 9)
                ftype = log_code;
            else if (i == 5)
                ftype = report_code;
            else if (i == QUEUE_DEPTH - 1)
                ftype = '1;
            else
                ftype = TYPE_W'(8'h40 + i);
            seq = (i % 2) ? SEQ_AUTO : SEQ_W'(255 - i);
            if (i == 0)
                length = '0;
            else if (i == 1)
                length = LEN_W'(MAX_PAYLOAD);
            else
                length = LEN_W'(i * 31);
            if (i == 0)
                handle = '0;
            else if (i == 1)
                handle = '1;
            else
                handle = HANDLE_W'(16'h1000 + i);
            issue_frame(make_enqueue(ftype, seq, length, handle, MODE_W'($urandom_range(0, 3))));
        end
    endtask

    // Full queue: rejections, log eviction, report fallback, nothing to evict
    task automatic test_full_queue_rules();
        issue_frame(make_enqueue(8'h7E, 8'h10, 10'd5, 16'h2000, EVICT_NONE));
        issue_frame(make_enqueue(8'h7E, 8'h11, 10'd5, 16'h2001, EVICT_SPARE));
        issue_frame(make_enqueue(8'h7E, SEQ_AUTO, '1, 16'h2002, EVICT_LOG));
        issue_frame(make_enqueue(8'h7E, SEQ_AUTO, LEN_W'(MAX_PAYLOAD + 1), 16'h2003,
                                 EVICT_LOG_REPORT));
        issue_frame(make_enqueue(8'h7E, SEQ_AUTO, 10'd7, 16'h2004, EVICT_LOG));
        issue_frame(make_enqueue(8'h7E, 8'h80, 10'd8, 16'h2005, EVICT_LOG));
        issue_frame(make_enqueue(8'h7E, 8'h81, 10'd9, 16'h2006, EVICT_LOG));
        issue_frame(make_enqueue(8'h7E, SEQ_AUTO, 10'd10, 16'h2007, EVICT_LOG_REPORT));
        issue_frame(make_enqueue(8'h7E, SEQ_AUTO, 10'd11, 16'h2008, EVICT_LOG_REPORT));
    endtask

    task automatic test_take_and_clear();
        issue_frame(make_op(FUNC_TAKE));
        issue_frame(make_op(FUNC_TAKE));
        issue_frame(make_op(FUNC_CLEAR));
        issue_frame(make_op(FUNC_TAKE));
    endtask

    // Auto-numbered frames until the counter wraps past 255, clearing when full
    task automatic test_sequence_wrap();
        frame_req_t r;
        int         guard;
        int         tail_items;
        guard = 0;
        tail_items = 0;
        while (guard < 400 && tail_items < 12)
        begin
            if (held_frames.size() >= QUEUE_DEPTH && $urandom_range(0, 3) != 0)
                r = make_op(FUNC_CLEAR);
            else if ($urandom_range(0, 7) == 0)
                r = make_op(FUNC_TAKE);
            else
                r = make_enqueue(pick_type(), SEQ_AUTO, LEN_W'($urandom_range(0, MAX_PAYLOAD)),
                                 HANDLE_W'($urandom), MODE_W'($urandom_range(0, 3)));
            issue_frame(r);
            guard++;
            if (seq_wrapped)
                tail_items++;
        end
    endtask

    // One class-code setting, then mixed random traffic
    task automatic run_traffic_phase(input logic [CFG_DATA_W-1:0] log_val,
                                     input logic [CFG_DATA_W-1:0] report_val,
                                     input int n_items, input int enq_pct);
        wait_for_idle();
        set_codes(log_val, report_val);
        repeat (n_items) issue_frame(random_frame(enq_pct));
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] shared;
        shared = CFG_DATA_W'($urandom);
        run_traffic_phase('1, '0, 75, 80);
        run_traffic_phase('0, '1, 75, 75);
        run_traffic_phase(shared, shared, 60, 80);
        run_traffic_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), 75, 55);
        run_traffic_phase(LOG_CODE_RESET, REPORT_CODE_RESET, 60, 70);
    endtask

    task automatic compare_field(input string name, input logic [15:0] exp_val,
                                 input logic [15:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     exp_val, act_val);
            mismatches++;
        end
    endtask

    // Result checker: every done strobe is matched against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, nothing pending", $time);
                mismatches++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                compare_field("accepted", 16'(oldest_result.accepted), 16'(accepted));
                compare_field("head_valid", 16'(oldest_result.head_valid), 16'(head_valid));
                compare_field("head_type", 16'(oldest_result.head_type), 16'(head_type));
                compare_field("head_seq", 16'(oldest_result.head_seq), 16'(head_seq));
                compare_field("head_length", 16'(oldest_result.head_length),
                              16'(head_length));
                compare_field("head_handle", oldest_result.head_handle, head_handle);
                compare_field("dropped", 16'(oldest_result.dropped), 16'(dropped));
                compare_field("dropped_handle", oldest_result.dropped_handle, dropped_handle);
                compare_field("entries_held", 16'(oldest_result.entries_held),
                              16'(entries_held));
                compare_field("irq_level", 16'(oldest_result.irq_level), 16'(irq_level));
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    // Test sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_fill_queue();
        test_full_queue_rules();
        test_take_and_clear();
        test_sequence_wrap();
        test_random_traffic();
        wait_for_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== outbound_frame_queue_evict.f =====
+incdir+src
src/ofqe_pkg.sv
src/ofqe_ctrl.sv
src/ofqe_datapath.sv
src/outbound_frame_queue_evict.sv
test/outbound_frame_queue_evict_tb.sv
